[rtl/gbc_pkg.sv]
package gbc_pkg;

  // field widths
  localparam int RATE_W     = 16;
  localparam int OUT_W      = 21;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int ATT_W      = 4;
  localparam int STAT_W     = 3;
  localparam int AXIS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS = 2'd2;

  // configuration reset values
  localparam logic [CNT_W-1:0] WINDOW_RST   = 16'd1000;
  localparam logic [CNT_W-1:0] SPREAD_RST   = 16'd200;
  localparam logic [ATT_W-1:0] ATTEMPTS_RST = 4'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_COLLECT    = 3'd0;
  localparam logic [STAT_W-1:0] ST_MOTION     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STAT_W-1:0] ST_CALIBRATED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FAILED     = 3'd4;
  localparam logic [STAT_W-1:0] ST_CORRECTED  = 3'd5;
  localparam logic [STAT_W-1:0] ST_DROPPED    = 3'd6;

  // which kind of result the controller asks the datapath to load
  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_COLLECT,
    KIND_REJECT,
    KIND_CAL
  } out_kind_t;

  typedef struct packed {
    logic              capture;
    logic              accum;
    logic              clear_win;
    logic              set_done;
    logic              inc_attempt;
    logic              div_start;
    logic              bias_load;
    logic              out_load;
    out_kind_t         kind;
    logic [AXIS_W-1:0] axis;
  } gbc_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic win_end;
    logic good_zero;
    logic reject;
    logic last_attempt;
    logic out_free;
    logic div_done;
  } gbc_sts_t;

endpackage

[rtl/gbc_div.sv]
module gbc_div #(
  parameter int FRACTION_BITS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gbc_pkg::SUM_W-1:0]  dividend,
  input  logic [gbc_pkg::CNT_W-1:0]  divisor,
  input  logic                       negate,
  output logic                       done,
  output logic [gbc_pkg::OUT_W-1:0]  quotient
);
  import gbc_pkg::*;

  localparam int DW = SUM_W + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W-1:0] rem_r;
  logic [OUT_W-1:0] q_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;
  logic [CNT_W-1:0] rem_nxt;

  // one restoring step per cycle
  assign trial   = {rem_r, dvd_r[DW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DW'(dividend) << FRACTION_BITS;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= negate;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[OUT_W-2:0], fits};
    end
  end

  // only the low quotient bits are kept, sign applied at the end
  assign quotient = neg_r ? (~q_r + OUT_W'(1)) : q_r;
  assign done     = done_r;

endmodule

[rtl/gbc_datapath.sv]
module gbc_datapath #(
  parameter int AXES          = 3,
  parameter int FRACTION_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [gbc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [gbc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [gbc_pkg::STAT_W-1:0]      out_tuser,
  input  gbc_pkg::gbc_cmd_t               cmd,
  output gbc_pkg::gbc_sts_t               sts
);
  import gbc_pkg::*;

  localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int PAD_W = OUT_DATA_W - (3 * OUT_W + CNT_W + AXIS_W + ATT_W);

  // configuration registers
  logic [CNT_W-1:0] win_size_r;
  logic [CNT_W-1:0] spread_lim_r;
  logic [ATT_W-1:0] max_att_r;

  // captured input item
  logic                     ok_r;
  logic signed [RATE_W-1:0] raw_r [AXES];

  // window and calibration state
  logic signed [SUM_W-1:0]  sum_r  [AXES];
  logic signed [RATE_W-1:0] min_r  [AXES];
  logic signed [RATE_W-1:0] max_r  [AXES];
  logic [OUT_W-1:0]         bias_r [AXES];
  logic [CNT_W-1:0]         good_r;
  logic [CNT_W-1:0]         slot_r;
  logic [ATT_W-1:0]         attempt_r;
  logic                     done_r;

  // result register
  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [OUT_W-1:0]         out_rate_r [3];
  logic [OUT_W-1:0]         out_rate_nxt [3];
  logic [CNT_W-1:0]         out_spread_r, out_spread_nxt;
  logic [AXIS_W-1:0]        out_axis_r, out_axis_nxt;
  logic [ATT_W-1:0]         out_att_r;

  logic [CNT_W-1:0]  win_eff;
  logic [ATT_W-1:0]  att_lim;
  logic [CNT_W-1:0]  worst_sp;
  logic [AXIS_W-1:0] worst_ax;
  logic [CNT_W:0]    spread_diff [AXES];
  logic [OUT_W-1:0]  corr [3];
  logic [AX_W-1:0]   axis_i;
  logic [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]  sum_mag;
  logic              sum_neg;
  logic              div_done;
  logic [OUT_W-1:0]  div_q;
  logic              out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r   <= WINDOW_RST;
      spread_lim_r <= SPREAD_RST;
      max_att_r    <= ATTEMPTS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW:   win_size_r   <= cfg_data;
        REG_SPREAD:   spread_lim_r <= cfg_data;
        REG_ATTEMPTS: max_att_r    <= cfg_data[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_r <= in_tuser;
      for (int a = 0; a < AXES; a++) begin
        raw_r[a] <= in_tdata[a*RATE_W +: RATE_W];
      end
    end
  end

  // window accumulation, attempt count and bias
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        sum_r[a]  <= '0;
        min_r[a]  <= '0;
        max_r[a]  <= '0;
        bias_r[a] <= '0;
      end
      good_r    <= '0;
      slot_r    <= '0;
      attempt_r <= ATT_W'(1);
      done_r    <= 1'b0;
    end else begin
      if (cmd.accum) begin
        if (ok_r) begin
          for (int a = 0; a < AXES; a++) begin
            sum_r[a] <= sum_r[a] + SUM_W'(raw_r[a]);
            if (good_r == '0 || raw_r[a] < min_r[a]) min_r[a] <= raw_r[a];
            if (good_r == '0 || raw_r[a] > max_r[a]) max_r[a] <= raw_r[a];
          end
          good_r <= good_r + 1'b1;
        end
        slot_r <= slot_r + 1'b1;
      end
      if (cmd.clear_win) begin
        for (int a = 0; a < AXES; a++) begin
          sum_r[a] <= '0;
          min_r[a] <= '0;
          max_r[a] <= '0;
        end
        good_r <= '0;
        slot_r <= '0;
      end
      if (cmd.set_done)    done_r    <= 1'b1;
      if (cmd.inc_attempt) attempt_r <= attempt_r + 1'b1;
      if (cmd.bias_load)   bias_r[axis_i] <= div_q;
    end
  end

  // window end and attempt limit, zero acts as one
  assign win_eff = (win_size_r == '0) ? CNT_W'(1) : win_size_r;
  assign att_lim = (max_att_r == '0) ? ATT_W'(1) : max_att_r;

  // largest spread, first axis wins ties
  always_comb begin
    worst_sp = '0;
    worst_ax = '0;
    for (int a = 0; a < AXES; a++) begin
      spread_diff[a] = {max_r[a][RATE_W-1], max_r[a]} - {min_r[a][RATE_W-1], min_r[a]};
      if (spread_diff[a][CNT_W-1:0] > worst_sp) begin
        worst_sp = spread_diff[a][CNT_W-1:0];
        worst_ax = AXIS_W'(a);
      end
    end
  end

  // divider operand select, sign and magnitude of the sum
  assign axis_i  = cmd.axis[AX_W-1:0];
  assign sum_sel = sum_r[axis_i];
  assign sum_neg = sum_sel[SUM_W-1];
  assign sum_mag = sum_neg ? (~sum_sel + SUM_W'(1)) : sum_sel;

  gbc_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (good_r),
    .negate   (sum_neg),
    .done     (div_done),
    .quotient (div_q)
  );

  // corrected rates in fixed point, absent axes read as zero
  for (genvar o = 0; o < 3; o++) begin : g_corr
    if (o < AXES) begin : g_on
      logic [OUT_W-1:0] raw_ext;
      assign raw_ext = {{(OUT_W-RATE_W){raw_r[o][RATE_W-1]}}, raw_r[o]};
      assign corr[o] = (raw_ext << FRACTION_BITS) - bias_r[o];
    end else begin : g_off
      assign corr[o] = '0;
    end
  end

  // next result
  always_comb begin
    out_status_nxt = ST_COLLECT;
    out_spread_nxt = '0;
    out_axis_nxt   = '0;
    for (int o = 0; o < 3; o++) out_rate_nxt[o] = '0;
    case (cmd.kind)
      KIND_SAMPLE: begin
        if (ok_r) begin
          out_status_nxt = ST_CORRECTED;
          for (int o = 0; o < 3; o++) out_rate_nxt[o] = corr[o];
        end else begin
          out_status_nxt = ST_DROPPED;
        end
      end
      KIND_COLLECT: out_status_nxt = ST_COLLECT;
      KIND_REJECT: begin
        if (good_r == '0) begin
          out_status_nxt = sts.last_attempt ? ST_FAILED : ST_EMPTY;
        end else begin
          out_status_nxt = sts.last_attempt ? ST_FAILED : ST_MOTION;
          out_spread_nxt = worst_sp;
          out_axis_nxt   = worst_ax;
        end
      end
      KIND_CAL: begin
        out_status_nxt = ST_CALIBRATED;
        out_spread_nxt = worst_sp;
        out_axis_nxt   = worst_ax;
      end
      default: ;
    endcase
  end

  // result register, free again once its transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= out_status_nxt;
      out_spread_r <= out_spread_nxt;
      out_axis_r   <= out_axis_nxt;
      out_att_r    <= attempt_r;
      for (int o = 0; o < 3; o++) out_rate_r[o] <= out_rate_nxt[o];
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_att_r, out_axis_r, out_spread_r,
                       out_rate_r[2], out_rate_r[1], out_rate_r[0]};

  // status to the controller
  assign sts.phase_done   = done_r;
  assign sts.win_end      = slot_r >= win_eff;
  assign sts.good_zero    = good_r == '0;
  assign sts.reject       = worst_sp > spread_lim_r;
  assign sts.last_attempt = attempt_r >= att_lim;
  assign sts.out_free     = out_free;
  assign sts.div_done     = div_done;

endmodule

[rtl/gbc_ctrl.sv]
module gbc_ctrl #(
  parameter int AXES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gbc_pkg::gbc_sts_t sts,
  output gbc_pkg::gbc_cmd_t cmd
);
  import gbc_pkg::*;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_EVAL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;

  // state and axis sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.kind  = KIND_COLLECT;
    cmd.axis  = axis_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.phase_done) begin
          // correction phase: one result per sample
          cmd.kind = KIND_SAMPLE;
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.accum = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.win_end) begin
          cmd.kind = KIND_COLLECT;
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.good_zero || sts.reject) begin
          // window rejected: retry or give up
          cmd.kind = KIND_REJECT;
          if (sts.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.clear_win   = 1'b1;
            cmd.set_done    = sts.last_attempt;
            cmd.inc_attempt = !sts.last_attempt;
            state_nxt       = S_IDLE;
          end
        end else begin
          axis_nxt  = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.bias_load = 1'b1;
          if (axis_r == LAST_AXIS) begin
            state_nxt = S_FINISH;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_FINISH: begin
        cmd.kind = KIND_CAL;
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.clear_win = 1'b1;
          cmd.set_done  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/gyro_bias_calibrate_correct.sv]
// Gyro zero-rate bias calibration and correction.
// Input stream: in_tdata carries the raw X, Y, Z rates, in_tuser the read-ok
// flag. Output stream: one result per input item, out_tuser the status code,
// out_tdata the corrected rates, window spread, peak axis and attempt.
// Configuration: cfg_index selects window size, spread limit or attempt limit;
// write only while no item is in flight. cfg_ready is always high.
// After reset the block collects calibration windows, then subtracts the
// Q.4 (FRACTION_BITS) bias from every good sample.
// Items are taken one at a time: a new item is accepted only once the last
// has loaded its result. A window that is accepted also runs the bit-serial
// divider once per axis, which forms each bias one quotient bit per cycle.
// Otherwise an item passes from the input capture register to the result
// register through S_STEP, and through S_STEP and S_EVAL while calibrating.
// Reset loads the default configuration, clears the window and bias, and
// restarts calibration at attempt 1.
// A stalled receiver holds the result in the output register; the next item
// is still taken, then waits inside the block until that register frees.
module gyro_bias_calibrate_correct #(
  parameter int AXES          = 3,
  parameter int FRACTION_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gbc_pkg::IN_DATA_W-1:0]   in_tdata,   // rate_in_x, rate_in_y, rate_in_z
  input  logic                            in_tuser,   // read_ok
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // rate_out_x, rate_out_y, rate_out_z, peak_spread, peak_axis, attempt_number, zero pad
  output logic [gbc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [gbc_pkg::STAT_W-1:0]      out_tuser   // status
);
  import gbc_pkg::*;

  gbc_cmd_t cmd;
  gbc_sts_t sts;

  assign cfg_ready = 1'b1;

  gbc_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbc_datapath #(
    .AXES          (AXES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
